/* rtl/core/mono_bitmap_color_expand_blit_assert.svh */
// ============================================================================
// Blitter assertion macros
// Shared concurrent-assertion shorthands; clk and rst_n must be in scope.
// ============================================================================
`ifndef MONO_BITMAP_COLOR_EXPAND_BLIT_ASSERT_SVH
`define MONO_BITMAP_COLOR_EXPAND_BLIT_ASSERT_SVH

// same-cycle implication
`define MBCX_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("blitter assertion failed");

// next-cycle implication
`define MBCX_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("blitter assertion failed");

`endif

/* rtl/core/mbcx_pkg.sv */
// ============================================================================
// Blitter package
// Field widths, command and register codes, and the pixel job record.
// ============================================================================
package mbcx_pkg;

    localparam int POS_W        = 12;
    localparam int DIM_W        = 13;
    localparam int COLOR_W      = 32;
    localparam int BYTE_W       = 8;
    localparam int PITCH_W      = 16;
    localparam int BPP_W        = 3;
    localparam int CNT_W        = 4;
    localparam int PIX_PER_BYTE = 8;
    localparam int IN_TDATA_W   = 96;
    localparam int CFG_IDX_W    = 2;

    // input tdata field offsets
    localparam int X_LSB     = 0;
    localparam int Y_LSB     = X_LSB + POS_W;
    localparam int COLOR_LSB = Y_LSB + POS_W;
    localparam int W_LSB     = COLOR_LSB + COLOR_W;
    localparam int H_LSB     = W_LSB + DIM_W;
    localparam int BYTE_LSB  = H_LSB + DIM_W;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_FB_BASE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_PITCH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BPP        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_ENABLE  = 2'd3;

    localparam logic [BPP_W-1:0] BPP_RESET = 3'd4;

    // one bitmap byte ready for expansion (address travels beside it)
    typedef struct packed {
        logic               done;
        logic [COLOR_W-1:0] color;
        logic [CNT_W-1:0]   cnt;
        logic [BYTE_W-1:0]  bits;
    } job_info_t;

endpackage

/* rtl/core/mbcx_front.sv */
// ============================================================================
// Blitter front end
// Accepts start and data transactions, tracks the blit and issues pixel jobs.
// ============================================================================
`include "mono_bitmap_color_expand_blit_assert.svh"

module mbcx_front #(
    parameter int ADDR_BITS = 48
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mbcx_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                              s_tuser,
    input  logic [ADDR_BITS-1:0]              fb_base,
    input  logic [mbcx_pkg::PITCH_W-1:0]      line_pitch,
    input  logic [mbcx_pkg::BPP_W-1:0]        bytes_per_pixel,
    input  logic                              fb_enable,
    output logic                              job_valid,
    input  logic                              job_ready,
    output logic [ADDR_BITS-1:0]              job_addr,
    output mbcx_pkg::job_info_t               job_info
);
    import mbcx_pkg::*;

    localparam int PY_W   = POS_W + PITCH_W;
    localparam int PX_W   = POS_W + BPP_W;
    localparam int STEP_W = CNT_W + BPP_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_ADDR = 2'b10
    } front_state_t;

    front_state_t state_reg, state_next;

    logic [ADDR_BITS-1:0] row_start_reg, row_start_next;
    logic [ADDR_BITS-1:0] pixel_addr_reg, pixel_addr_next;
    logic [DIM_W-1:0]     pl_reg, pl_next;
    logic [DIM_W-1:0]     rows_reg, rows_next;
    logic [DIM_W-1:0]     width_reg, width_next;
    logic [COLOR_W-1:0]   color_reg, color_next;
    logic [PY_W-1:0]      prod_y_reg, prod_y_next;
    logic [PX_W-1:0]      prod_x_reg, prod_x_next;

    logic [POS_W-1:0]     in_x, in_y;
    logic [DIM_W-1:0]     in_w, in_h;
    logic [BYTE_W-1:0]    in_byte;
    logic                 accept, live;
    logic [CNT_W-1:0]     n;
    logic [STEP_W-1:0]    step;
    logic [DIM_W-1:0]     pl_rem, rows_dec;
    logic [ADDR_BITS-1:0] next_row;

    assign in_x    = s_tdata[X_LSB +: POS_W];
    assign in_y    = s_tdata[Y_LSB +: POS_W];
    assign in_w    = s_tdata[W_LSB +: DIM_W];
    assign in_h    = s_tdata[H_LSB +: DIM_W];
    assign in_byte = s_tdata[BYTE_LSB +: BYTE_W];

    assign s_tready = (state_reg == ST_IDLE) && job_ready;
    assign accept   = s_tvalid && s_tready;
    assign live     = (rows_reg != '0) && fb_enable && (pl_reg != '0);
    assign n        = (pl_reg < DIM_W'(PIX_PER_BYTE)) ? pl_reg[CNT_W-1:0]
                                                      : CNT_W'(PIX_PER_BYTE);
    assign step     = STEP_W'(n) * STEP_W'(bytes_per_pixel);
    assign pl_rem   = pl_reg - DIM_W'(n);
    assign rows_dec = rows_reg - DIM_W'(1);
    assign next_row = row_start_reg + ADDR_BITS'(line_pitch);

    assign job_valid      = accept && (s_tuser == CMD_DATA) && live;
    assign job_addr       = pixel_addr_reg;
    assign job_info.bits  = in_byte;
    assign job_info.cnt   = n;
    assign job_info.color = color_reg;
    assign job_info.done  = (rows_reg == DIM_W'(1)) && (pl_rem == '0);

    always_comb
    begin
        state_next      = state_reg;
        row_start_next  = row_start_reg;
        pixel_addr_next = pixel_addr_reg;
        pl_next         = pl_reg;
        rows_next       = rows_reg;
        width_next      = width_reg;
        color_next      = color_reg;
        prod_y_next     = prod_y_reg;
        prod_x_next     = prod_x_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (s_tuser == CMD_START))
                begin
                    // products now, the address sum in the next cycle
                    prod_y_next = PY_W'(in_y) * PY_W'(line_pitch);
                    prod_x_next = PX_W'(in_x) * PX_W'(bytes_per_pixel);
                    color_next  = s_tdata[COLOR_LSB +: COLOR_W];
                    width_next  = in_w;
                    pl_next     = in_w;
                    rows_next   = (in_w == '0) ? '0 : in_h;
                    state_next  = ST_ADDR;
                end
                else if (job_valid)
                begin
                    if (pl_rem == '0)
                    begin
                        // row finished: drop one pitch
                        rows_next       = rows_dec;
                        row_start_next  = next_row;
                        pixel_addr_next = next_row;
                        pl_next         = (rows_dec == '0) ? '0 : width_reg;
                    end
                    else
                    begin
                        pl_next         = pl_rem;
                        pixel_addr_next = pixel_addr_reg + ADDR_BITS'(step);
                    end
                end
            end
            ST_ADDR:
            begin
                row_start_next  = fb_base + ADDR_BITS'(prod_y_reg) + ADDR_BITS'(prod_x_reg);
                pixel_addr_next = row_start_next;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            row_start_reg  <= '0;
            pixel_addr_reg <= '0;
            pl_reg         <= '0;
            rows_reg       <= '0;
            width_reg      <= '0;
            color_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            row_start_reg  <= row_start_next;
            pixel_addr_reg <= pixel_addr_next;
            pl_reg         <= pl_next;
            rows_reg       <= rows_next;
            width_reg      <= width_next;
            color_reg      <= color_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_y_reg <= prod_y_next;
        prod_x_reg <= prod_x_next;
    end

    `MBCX_ASSERT_NEXT(a_addr_phase_one_cycle, state_reg == ST_ADDR, state_reg == ST_IDLE)
    `MBCX_ASSERT_NEXT(a_done_ends_blit, job_valid && job_info.done, rows_reg == '0)

endmodule

/* rtl/core/mbcx_fifo.sv */
// ============================================================================
// Blitter job queue
// Small register FIFO between the front end and the pixel writer.
// ============================================================================
`include "mono_bitmap_color_expand_blit_assert.svh"

module mbcx_fifo #(
    parameter int WIDTH = 93,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entries_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= wr_data;
    end

    `MBCX_ASSERT_NOW(a_empty_ptrs_meet, count_reg == '0, rd_ptr_reg == wr_ptr_reg)

endmodule

/* rtl/core/mbcx_back.sv */
// ============================================================================
// Blitter pixel writer
// Expands one queued byte into framebuffer writes, one per cycle unless the output stalls.
// ============================================================================
`include "mono_bitmap_color_expand_blit_assert.svh"

module mbcx_back #(
    parameter int ADDR_BITS = 48
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [mbcx_pkg::BPP_W-1:0]    bytes_per_pixel,
    input  logic                          job_valid,
    output logic                          job_ready,
    input  logic [ADDR_BITS-1:0]          job_addr,
    input  mbcx_pkg::job_info_t           job_info,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ADDR_BITS-1:0]          out_addr,
    output logic [mbcx_pkg::COLOR_W-1:0]  out_data,
    output logic                          out_last,
    output logic                          out_done
);
    import mbcx_pkg::*;

    logic                 active_reg, active_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [BYTE_W-1:0]    bits_reg, bits_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [COLOR_W-1:0]   color_reg, color_next;
    logic                 done_reg, done_next;

    logic                 ovalid_reg, ovalid_next;
    logic [ADDR_BITS-1:0] oaddr_reg, oaddr_next;
    logic [COLOR_W-1:0]   odata_reg, odata_next;
    logic                 olast_reg, olast_next;
    logic                 odone_reg, odone_next;

    logic emit, beat_last, pop;

    assign emit      = active_reg && (!ovalid_reg || out_ready);
    assign beat_last = (cnt_reg == CNT_W'(1));
    assign job_ready = !active_reg || (emit && beat_last);
    assign pop       = job_valid && job_ready;

    assign out_valid = ovalid_reg;
    assign out_addr  = oaddr_reg;
    assign out_data  = odata_reg;
    assign out_last  = olast_reg;
    assign out_done  = odone_reg;

    always_comb
    begin
        active_next = active_reg;
        addr_next   = addr_reg;
        bits_next   = bits_reg;
        cnt_next    = cnt_reg;
        color_next  = color_reg;
        done_next   = done_reg;
        ovalid_next = ovalid_reg;
        oaddr_next  = oaddr_reg;
        odata_next  = odata_reg;
        olast_next  = olast_reg;
        odone_next  = odone_reg;

        if (emit)
        begin
            ovalid_next = 1'b1;
            oaddr_next  = addr_reg;
            odata_next  = bits_reg[BYTE_W-1] ? color_reg : '0;
            olast_next  = beat_last;
            odone_next  = beat_last && done_reg;
            addr_next   = addr_reg + ADDR_BITS'(bytes_per_pixel);
            bits_next   = {bits_reg[BYTE_W-2:0], 1'b0};
            cnt_next    = cnt_reg - CNT_W'(1);
            if (beat_last)
                active_next = 1'b0;
        end
        else if (out_ready)
        begin
            ovalid_next = 1'b0;
        end

        // next job loads when idle or behind the final beat of the current one
        if (pop)
        begin
            active_next = 1'b1;
            addr_next   = job_addr;
            bits_next   = job_info.bits;
            cnt_next    = job_info.cnt;
            color_next  = job_info.color;
            done_next   = job_info.done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        bits_reg  <= bits_next;
        cnt_reg   <= cnt_next;
        color_reg <= color_next;
        done_reg  <= done_next;
        oaddr_reg <= oaddr_next;
        odata_reg <= odata_next;
        olast_reg <= olast_next;
        odone_reg <= odone_next;
    end

    `MBCX_ASSERT_NOW(a_done_only_on_last, ovalid_reg && odone_reg, olast_reg)
    `MBCX_ASSERT_NEXT(a_job_drains, emit && beat_last && !pop, !active_reg)

endmodule

/* rtl/core/mono_bitmap_color_expand_blit.sv */
// A data transaction reaches m_tdata through the job queue, the writer's job registers
//   and its output register. A byte gives one write per pixel it covers (up to 8) through
//   the writer's single output port; a start runs a multiply, then the address sum.
// A 4-entry job queue lets the front end take bytes while the writer drains earlier ones.
// Reset: rst_n is asynchronous, active low; it clears the blit state, the queue, the
//   output valid and the registers (bytes_per_pixel to 4, all others to zero).
// ============================================================================
// Monochrome color-expansion blitter
// Turns a packed 1-bit bitmap into 32-bit framebuffer pixel writes.
// ============================================================================
module mono_bitmap_color_expand_blit #(
    parameter int ADDR_BITS = 48
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mbcx_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ADDR_BITS-1:0]              cfg_data,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata, LSB up: pos_x[11:0], pos_y[11:0], fg_color[31:0], bmp_width[12:0],
    //   bmp_height[12:0], data_byte[7:0], zero pad to 96 bits
    input  logic [mbcx_pkg::IN_TDATA_W-1:0]   s_tdata,
    // tuser: command (0 start, 1 data byte)
    input  logic                              s_tuser,
    // output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tdata, LSB up: write_addr[ADDR_BITS-1:0], write_data[31:0], zero pad to bytes
    output logic [((ADDR_BITS+mbcx_pkg::COLOR_W+7)/8)*8-1:0] m_tdata,
    // tlast: last write of this input transaction
    output logic                              m_tlast,
    // tuser: blit_done
    output logic                              m_tuser
);
    import mbcx_pkg::*;

    localparam int OUT_TDATA_W = ((ADDR_BITS + COLOR_W + 7) / 8) * 8;
    localparam int JOB_W       = ADDR_BITS + $bits(job_info_t);
    localparam int QUEUE_DEPTH = 4;

    // ---- configuration registers; user writes only while blitter is idle; not enforced
    logic [ADDR_BITS-1:0] fb_base_reg, fb_base_next;
    logic [PITCH_W-1:0]   pitch_reg, pitch_next;
    logic [BPP_W-1:0]     bpp_reg, bpp_next;
    logic                 enable_reg, enable_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        fb_base_next = fb_base_reg;
        pitch_next   = pitch_reg;
        bpp_next     = bpp_reg;
        enable_next  = enable_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FB_BASE:    fb_base_next = cfg_data;
                CFG_LINE_PITCH: pitch_next   = cfg_data[PITCH_W-1:0];
                CFG_BPP:        bpp_next     = cfg_data[BPP_W-1:0];
                CFG_FB_ENABLE:  enable_next  = cfg_data[0];
                default:        fb_base_next = fb_base_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_base_reg <= '0;
            pitch_reg   <= '0;
            bpp_reg     <= BPP_RESET;
            enable_reg  <= 1'b0;
        end
        else
        begin
            fb_base_reg <= fb_base_next;
            pitch_reg   <= pitch_next;
            bpp_reg     <= bpp_next;
            enable_reg  <= enable_next;
        end
    end

    // ---- front end: classifies transactions, walks rows, issues jobs
    logic                 fe_valid, fe_ready;
    logic [ADDR_BITS-1:0] fe_addr;
    job_info_t            fe_info;

    mbcx_front #(
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .fb_base         (fb_base_reg),
        .line_pitch      (pitch_reg),
        .bytes_per_pixel (bpp_reg),
        .fb_enable       (enable_reg),
        .job_valid       (fe_valid),
        .job_ready       (fe_ready),
        .job_addr        (fe_addr),
        .job_info        (fe_info)
    );

    // ---- job queue; each entry is {info, start address}
    logic             q_valid, q_ready;
    logic [JOB_W-1:0] q_data;

    mbcx_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fe_valid),
        .wr_ready (fe_ready),
        .wr_data  ({fe_info, fe_addr}),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    // ---- pixel writer with registered output
    logic [ADDR_BITS-1:0] wr_addr;
    logic [COLOR_W-1:0]   wr_data;

    mbcx_back #(
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .bytes_per_pixel (bpp_reg),
        .job_valid       (q_valid),
        .job_ready       (q_ready),
        .job_addr        (q_data[ADDR_BITS-1:0]),
        .job_info        (job_info_t'(q_data[JOB_W-1:ADDR_BITS])),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_addr        (wr_addr),
        .out_data        (wr_data),
        .out_last        (m_tlast),
        .out_done        (m_tuser)
    );

    assign m_tdata = OUT_TDATA_W'({wr_data, wr_addr});

endmodule
